@@ rtl/rcsa_pkg.sv @@
// Package for the reference-counted slot allocator.
// Holds field widths, request codes, status codes and the payload structs.
// No dependencies.
`timescale 1ns / 1ps

package rcsa_pkg;

    // Default values of the top-level parameters.
    localparam int SLOTS_DEF      = 1024;
    localparam int COUNT_BITS_DEF = 16;

    // Fixed field widths of the request and result channels.
    localparam int SLOT_W  = 10;
    localparam int COUNT_W = 16;
    localparam int TOTAL_W = 26;

    // Request kinds.
    localparam logic [1:0] KIND_ALLOC   = 2'd0;
    localparam logic [1:0] KIND_ADD     = 2'd1;
    localparam logic [1:0] KIND_RELEASE = 2'd2;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_DEAD     = 2'd2,
        ST_OVERFLOW = 2'd3
    } t_status;

    // Request payload.
    typedef struct packed {
        logic [1:0]         kind;
        logic [SLOT_W-1:0]  slot;
        logic [COUNT_W-1:0] count;
    } t_req;

    // Result payload.
    typedef struct packed {
        logic [SLOT_W-1:0]  slot_out;
        t_status            status;
        logic [TOTAL_W-1:0] total_refs;
    } t_rsp;

    // Free stack operation for the current request.
    typedef struct packed {
        logic push;
        logic pop;
    } t_stk_op;

endpackage

@@ rtl/rcsa_ifs.sv @@
// Valid/ready channel interfaces for requests and results.
// Depends on rcsa_pkg for the payload structs.
`timescale 1ns / 1ps

interface rcsa_req_if;
    logic          valid;
    logic          ready;
    rcsa_pkg::t_req data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface rcsa_rsp_if;
    logic          valid;
    logic          ready;
    rcsa_pkg::t_rsp data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/rcsa_count_mem.sv @@
// Reference count memory with a fill count that marks never-used slots.
// Slots at or above the fill count read as zero; slot 0 reads as one until written.
// Depends on nothing outside this file.
`timescale 1ns / 1ps

module rcsa_count_mem #(
    parameter int SLOTS      = 1024,
    parameter int COUNT_BITS = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_rd_en,
    input  logic [$clog2(SLOTS)-1:0] i_rd_addr,
    input  logic                     i_wr_en,
    input  logic [$clog2(SLOTS)-1:0] i_wr_addr,
    input  logic [COUNT_BITS-1:0]    i_wr_data,
    input  logic                     i_take_fresh,
    output logic [COUNT_BITS-1:0]    o_rd_data,
    output logic [$clog2(SLOTS)-1:0] o_fresh_slot,
    output logic                     o_fresh_avail
);
    localparam int SW = $clog2(SLOTS);

    logic [COUNT_BITS-1:0] r_mem [SLOTS];
    logic [COUNT_BITS-1:0] r_q;
    logic                  r_rd_unused;
    logic                  r_rd_seed;
    logic                  r_seed0;
    logic [SW:0]           r_next;
    logic [SW:0]           n_next;

    // Synchronous write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Synchronous read port with registered data.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_q <= r_mem[i_rd_addr];
        end
    end

    // Read qualifiers: never-used slot, or slot 0 still at its reset value.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_unused <= ({1'b0, i_rd_addr} >= r_next);
            r_rd_seed   <= (i_rd_addr == '0) && r_seed0;
        end
    end

    // Fill count of slots that have been handed out at least once.
    always_comb begin
        n_next = r_next;
        if (i_take_fresh) begin
            n_next = r_next + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_next  <= (SW+1)'(1);
            r_seed0 <= 1'b1;
        end else begin
            r_next <= n_next;
            if (i_wr_en && (i_wr_addr == '0)) begin
                r_seed0 <= 1'b0;
            end
        end
    end

    always_comb begin
        if (r_rd_unused) begin
            o_rd_data = '0;
        end else if (r_rd_seed) begin
            o_rd_data = COUNT_BITS'(1);
        end else begin
            o_rd_data = r_q;
        end
    end

    assign o_fresh_slot  = SW'(r_next);
    assign o_fresh_avail = (r_next < (SW+1)'(SLOTS));

endmodule

@@ rtl/rcsa_free_stack.sv @@
// LIFO stack of freed slots held in a synchronous memory.
// The top entry is read ahead into a register; push and pop update the pointer.
// Depends on rcsa_pkg for the stack operation struct.
`timescale 1ns / 1ps

module rcsa_free_stack #(
    parameter int SLOTS = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_rd_en,
    input  rcsa_pkg::t_stk_op        i_op,
    input  logic [$clog2(SLOTS)-1:0] i_push_slot,
    output logic [$clog2(SLOTS)-1:0] o_top_slot,
    output logic                     o_empty,
    output logic                     o_full
);
    localparam int SW = $clog2(SLOTS);

    logic [SW-1:0] r_mem [SLOTS];
    logic [SW-1:0] r_q;
    logic [SW:0]   r_top;
    logic [SW:0]   n_top;
    logic [SW:0]   top_less;

    assign top_less = r_top - 1'b1;

    // Push writes the entry at the current pointer.
    always_ff @(posedge i_clk) begin
        if (i_op.push) begin
            r_mem[SW'(r_top)] <= i_push_slot;
        end
    end

    // Read of the top entry, registered.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_q <= r_mem[SW'(top_less)];
        end
    end

    // Stack pointer.
    always_comb begin
        n_top = r_top;
        if (i_op.push) begin
            n_top = r_top + 1'b1;
        end else if (i_op.pop) begin
            n_top = top_less;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top <= '0;
        end else begin
            r_top <= n_top;
        end
    end

    assign o_top_slot = r_q;
    assign o_empty    = (r_top == '0);
    assign o_full     = (r_top >= (SW+1)'(SLOTS));

endmodule

@@ rtl/refcounted_slot_allocator_top.sv @@
// Top level of the reference-counted slot allocator.
// Depends on rcsa_pkg, rcsa_ifs, rcsa_count_mem and rcsa_free_stack.
//
//   Port    Direction  Payload                       Transfer when
//   i_req   in         kind, slot, count             valid && ready
//   o_rsp   out        slot_out, status, total_refs  valid && ready
//
// A request is read from the count memory and the free stack when it is
// accepted, then modified and written back in S_EXEC. Both memories have
// one read and one write port each. The result register frees the input
// side; a request waits in S_EXEC only while an earlier result has not been
// taken. Never-used slots are tracked by a fill count, so there is no
// clearing pass over the count memory.
`timescale 1ns / 1ps

module refcounted_slot_allocator_top #(
    parameter int SLOTS      = rcsa_pkg::SLOTS_DEF,
    parameter int COUNT_BITS = rcsa_pkg::COUNT_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rcsa_req_if.sink    i_req,
    rcsa_rsp_if.source  o_rsp
);
    localparam int SW     = $clog2(SLOTS);
    localparam int SO_W   = rcsa_pkg::SLOT_W;
    localparam int CNT_W  = rcsa_pkg::COUNT_W;
    localparam int TOT_W  = rcsa_pkg::TOTAL_W;
    localparam int SUM_W  = ((COUNT_BITS > CNT_W) ? COUNT_BITS : CNT_W) + 1;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    t_state              r_state;
    t_state              n_state;
    logic [1:0]          r_kind;
    logic [SO_W-1:0]     r_slot;
    logic [CNT_W-1:0]    r_count;
    logic                r_in_range;
    logic [TOT_W-1:0]    r_total;
    logic [TOT_W-1:0]    n_total;
    logic                r_out_valid;
    rcsa_pkg::t_rsp      r_out;

    logic                accept;
    logic                fire;
    logic [SW-1:0]       slot_idx;
    logic [COUNT_BITS-1:0] cur_count;
    logic [SW-1:0]       fresh_slot;
    logic                fresh_avail;
    logic [SW-1:0]       stk_slot;
    logic                stk_empty;
    logic                stk_full;
    logic                live;
    logic [SUM_W-1:0]    add_sum;
    logic                add_ovf;

    logic                cm_wr;
    logic [SW-1:0]       cm_wr_addr;
    logic [COUNT_BITS-1:0] cm_wr_data;
    logic                take_fresh;
    rcsa_pkg::t_stk_op   stk_op;
    rcsa_pkg::t_stk_op   stk_op_q;
    rcsa_pkg::t_status   status;
    logic [SO_W-1:0]     res_slot;

    // Handshake on both channels.
    assign accept        = i_req.valid && i_req.ready;
    assign i_req.ready   = (r_state == S_IDLE);
    assign fire          = (r_state == S_EXEC) && (!r_out_valid || o_rsp.ready);
    assign o_rsp.valid   = r_out_valid;
    assign o_rsp.data    = r_out;

    // Request register, loaded at the input transfer.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind     <= i_req.data.kind;
            r_slot     <= i_req.data.slot;
            r_count    <= i_req.data.count;
            r_in_range <= (32'(i_req.data.slot) < 32'(SLOTS));
        end
    end

    assign slot_idx = SW'(r_slot);

    rcsa_count_mem #(
        .SLOTS      (SLOTS),
        .COUNT_BITS (COUNT_BITS)
    ) u_count_mem (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_rd_en       (accept),
        .i_rd_addr     (SW'(i_req.data.slot)),
        .i_wr_en       (fire && cm_wr),
        .i_wr_addr     (cm_wr_addr),
        .i_wr_data     (cm_wr_data),
        .i_take_fresh  (fire && take_fresh),
        .o_rd_data     (cur_count),
        .o_fresh_slot  (fresh_slot),
        .o_fresh_avail (fresh_avail)
    );

    assign stk_op_q.push = fire && stk_op.push;
    assign stk_op_q.pop  = fire && stk_op.pop;

    rcsa_free_stack #(
        .SLOTS (SLOTS)
    ) u_free_stack (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rd_en     (accept),
        .i_op        (stk_op_q),
        .i_push_slot (slot_idx),
        .o_top_slot  (stk_slot),
        .o_empty     (stk_empty),
        .o_full      (stk_full)
    );

    // Count checks for add and release.
    assign live    = r_in_range && (cur_count != '0);
    assign add_sum = SUM_W'(cur_count) + SUM_W'(r_count);
    assign add_ovf = ((add_sum >> COUNT_BITS) != '0);

    // Modify step: new count, stack operation, total and status.
    always_comb begin
        status     = rcsa_pkg::ST_OK;
        res_slot   = r_slot;
        n_total    = r_total;
        cm_wr      = 1'b0;
        cm_wr_addr = slot_idx;
        cm_wr_data = '0;
        take_fresh = 1'b0;
        stk_op     = '0;
        case (r_kind)
            rcsa_pkg::KIND_ALLOC: begin
                if (!stk_empty) begin
                    stk_op.pop = 1'b1;
                    cm_wr      = 1'b1;
                    cm_wr_addr = stk_slot;
                    cm_wr_data = COUNT_BITS'(1);
                    n_total    = r_total + 1'b1;
                    res_slot   = SO_W'(stk_slot);
                end else if (fresh_avail) begin
                    take_fresh = 1'b1;
                    cm_wr      = 1'b1;
                    cm_wr_addr = fresh_slot;
                    cm_wr_data = COUNT_BITS'(1);
                    n_total    = r_total + 1'b1;
                    res_slot   = SO_W'(fresh_slot);
                end else begin
                    status   = rcsa_pkg::ST_FULL;
                    res_slot = '0;
                end
            end
            rcsa_pkg::KIND_ADD: begin
                if (!live) begin
                    status = rcsa_pkg::ST_DEAD;
                end else if (add_ovf) begin
                    status = rcsa_pkg::ST_OVERFLOW;
                end else begin
                    cm_wr      = 1'b1;
                    cm_wr_data = COUNT_BITS'(add_sum);
                    n_total    = r_total + TOT_W'(r_count);
                end
            end
            rcsa_pkg::KIND_RELEASE: begin
                if (!live) begin
                    status = rcsa_pkg::ST_DEAD;
                end else begin
                    cm_wr      = 1'b1;
                    cm_wr_data = cur_count - 1'b1;
                    n_total    = r_total - 1'b1;
                    // Last reference gone: the slot goes back on the free stack unless it is full.
                    if ((cur_count == COUNT_BITS'(1)) && !stk_full) begin
                        stk_op.push = 1'b1;
                    end
                end
            end
            default: begin
                status = rcsa_pkg::ST_OK;
            end
        endcase
    end

    // Sequencer: read on acceptance in S_IDLE, then modify and write in S_EXEC.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (fire) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers and running total.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (fire) begin
                r_total     <= n_total;
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out.slot_out   <= res_slot;
            r_out.status     <= status;
            r_out.total_refs <= n_total;
        end
    end

`ifndef NO_ASSERTIONS
    a_accept_exec : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_EXEC))
        else $error("accepted request did not enter the modify cycle");

    a_no_overwrite : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_rsp.ready) |-> !fire)
        else $error("result register overwritten before its transfer");

    a_fire_valid : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |=> r_out_valid)
        else $error("completed request produced no result");

    a_stk_excl : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(stk_op_q.push && stk_op_q.pop))
        else $error("free stack push and pop in the same cycle");

    a_total_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !fire |=> $stable(r_total))
        else $error("reference total changed without a completed request");
`endif

endmodule

@@ bench/refcounted_slot_allocator_top_test.sv @@
// Self-checking bench for refcounted_slot_allocator_top: a queue-fed request driver,
// a result monitor, and a transaction-level mirror of the slot counts and the free stack.
// Depends on rcsa_pkg, rcsa_ifs and the allocator RTL.
`timescale 1ns / 1ps

module refcounted_slot_allocator_top_test;

    localparam int         SLOTS        = rcsa_pkg::SLOTS_DEF;
    localparam int         SLOT_W       = rcsa_pkg::SLOT_W;
    localparam int         COUNT_W      = rcsa_pkg::COUNT_W;
    localparam int         TOTAL_W      = rcsa_pkg::TOTAL_W;
    localparam logic [1:0] KIND_UNUSED  = 2'd3;
    localparam int         IDLE_PCT     = 22;
    localparam int         RANDOM_ITEMS = 2000;
    localparam int         HOLD_CYCLES  = 300;
    localparam int         STALL_LIMIT  = 5000;
    localparam int         MAX_REPORTS  = 10;

    typedef enum int {
        MIX_FILL,
        MIX_DRAIN,
        MIX_BLEND
    } t_mix;

    logic i_clk = 1'b0;
    logic i_rst_n;

    rcsa_req_if req_if ();
    rcsa_rsp_if rsp_if ();

    refcounted_slot_allocator_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    // Free-running clock, 2 ns period.
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Mirror of the allocator state, advanced once per accepted request.
    logic [COUNT_W-1:0] cnt_mirror [SLOTS];
    logic [SLOT_W-1:0]  freed_slots [SLOTS];
    int unsigned        freed_depth;
    int unsigned        fresh_slot;
    logic [TOTAL_W-1:0] ref_sum;
    bit                 full_seen;

    rcsa_pkg::t_req request_q [$];
    rcsa_pkg::t_rsp predicted_rsp_q [$];
    rcsa_pkg::t_rsp rsp_want;
    int unsigned    req_done;
    int unsigned    rsp_done;
    int unsigned    mismatches;
    int unsigned    stall_cycles;
    bit             hold_armed;
    bit             hold_taken;
    int             hold_left;

    // Scratch for building random batches.
    logic [COUNT_W-1:0] plan_cnt [SLOTS];
    int                 live_q [$];
    int                 light_q [$];

    function automatic void clear_allocator();
        foreach (cnt_mirror[i]) cnt_mirror[i] = '0;
        cnt_mirror[0] = COUNT_W'(1);
        freed_depth   = 0;
        fresh_slot    = 1;
        ref_sum       = '0;
    endfunction

    // Applies one request to the mirror and returns the result it must produce.
    function automatic rcsa_pkg::t_rsp predict_allocator_result(rcsa_pkg::t_req r);
        rcsa_pkg::t_rsp    res;
        logic [SLOT_W-1:0] s;
        logic [COUNT_W:0]  sum;
        res.slot_out = r.slot;
        res.status   = rcsa_pkg::ST_OK;
        s            = '0;
        case (r.kind)
            rcsa_pkg::KIND_ALLOC: begin
                // The most recently freed slot wins over a never-used one.
                if (freed_depth > 0) begin
                    freed_depth--;
                    s = freed_slots[freed_depth];
                end else if (fresh_slot < SLOTS) begin
                    s = SLOT_W'(fresh_slot);
                    fresh_slot++;
                end else begin
                    res.status = rcsa_pkg::ST_FULL;
                    full_seen  = 1'b1;
                end
                if (res.status == rcsa_pkg::ST_OK) begin
                    cnt_mirror[s] = COUNT_W'(1);
                    ref_sum       = ref_sum + 1'b1;
                    res.slot_out  = s;
                end else begin
                    res.slot_out = '0;
                end
            end
            rcsa_pkg::KIND_ADD: begin
                sum = {1'b0, cnt_mirror[r.slot]} + {1'b0, r.count};
                if (cnt_mirror[r.slot] == '0) begin
                    res.status = rcsa_pkg::ST_DEAD;
                end else if (sum[COUNT_W]) begin
                    res.status = rcsa_pkg::ST_OVERFLOW;
                end else begin
                    cnt_mirror[r.slot] = sum[COUNT_W-1:0];
                    ref_sum            = ref_sum + r.count;
                end
            end
            rcsa_pkg::KIND_RELEASE: begin
                if (cnt_mirror[r.slot] == '0) begin
                    res.status = rcsa_pkg::ST_DEAD;
                end else begin
                    cnt_mirror[r.slot] = cnt_mirror[r.slot] - 1'b1;
                    ref_sum            = ref_sum - 1'b1;
                    if (cnt_mirror[r.slot] == '0 && freed_depth < SLOTS) begin
                        freed_slots[freed_depth] = r.slot;
                        freed_depth++;
                    end
                end
            end
            default: begin
                // The unused kind only echoes the slot.
            end
        endcase
        res.total_refs = ref_sum;
        return res;
    endfunction

    // Random idling on both sides, switched off over a stretch in the middle of the run.
    function automatic bit idle_now();
        if (req_done >= 700 && req_done < 1100) return 1'b0;
        return $urandom_range(99) < IDLE_PCT;
    endfunction

    function automatic void push_req(logic [1:0] k, logic [SLOT_W-1:0] s,
                                     logic [COUNT_W-1:0] c);
        rcsa_pkg::t_req r;
        r.kind    = k;
        r.slot    = s;
        r.count   = c;
        request_q = {request_q, r};
    endfunction

    // Builds a batch of requests from the mirror as it stands while the block is idle.
    // Add and release mostly target live slots; release favors lightly held ones so
    // that slots actually return to the free stack.
    task queue_random_batch(int n, t_mix mix);
        int                 r;
        int                 s;
        rcsa_pkg::t_req     q;
        logic [COUNT_W-1:0] room;
        live_q.delete();
        light_q.delete();
        foreach (cnt_mirror[i]) begin
            plan_cnt[i] = cnt_mirror[i];
            if (cnt_mirror[i] != '0) begin
                live_q = {live_q, i};
                if (cnt_mirror[i] <= 3) light_q = {light_q, i};
            end
        end
        repeat (n) begin
            r       = $urandom_range(99);
            q.slot  = SLOT_W'($urandom());
            q.count = COUNT_W'($urandom());
            case (mix)
                MIX_FILL: begin
                    q.kind = (r < 80) ? rcsa_pkg::KIND_ALLOC :
                             (r < 90) ? rcsa_pkg::KIND_ADD :
                             (r < 97) ? rcsa_pkg::KIND_RELEASE : KIND_UNUSED;
                end
                MIX_DRAIN: begin
                    q.kind = (r < 10) ? rcsa_pkg::KIND_ALLOC :
                             (r < 25) ? rcsa_pkg::KIND_ADD :
                             (r < 92) ? rcsa_pkg::KIND_RELEASE : KIND_UNUSED;
                end
                default: begin
                    q.kind = (r < 35) ? rcsa_pkg::KIND_ALLOC :
                             (r < 65) ? rcsa_pkg::KIND_ADD :
                             (r < 95) ? rcsa_pkg::KIND_RELEASE : KIND_UNUSED;
                end
            endcase
            if ((q.kind == rcsa_pkg::KIND_ADD || q.kind == rcsa_pkg::KIND_RELEASE) &&
                live_q.size() != 0 && $urandom_range(99) < 85) begin
                if (q.kind == rcsa_pkg::KIND_RELEASE && light_q.size() != 0 &&
                    $urandom_range(99) < 70)
                    s = light_q[$urandom_range(light_q.size() - 1)];
                else
                    s = live_q[$urandom_range(live_q.size() - 1)];
                q.slot = SLOT_W'(s);
            end
            if (q.kind == rcsa_pkg::KIND_ADD) begin
                // Small adds, arbitrary adds, exactly to the ceiling, and one past it.
                room = '1 - plan_cnt[q.slot];
                r    = $urandom_range(99);
                if (r < 60)      q.count = COUNT_W'($urandom_range(3));
                else if (r < 88 && r >= 75) q.count = room;
                else if (r >= 88) q.count = room + 1'b1;
                if (plan_cnt[q.slot] != '0 &&
                    {1'b0, plan_cnt[q.slot]} + q.count <= {1'b0, room} + plan_cnt[q.slot])
                    plan_cnt[q.slot] = plan_cnt[q.slot] + q.count;
            end else if (q.kind == rcsa_pkg::KIND_RELEASE && plan_cnt[q.slot] != '0) begin
                plan_cnt[q.slot] = plan_cnt[q.slot] - 1'b1;
            end
            request_q = {request_q, q};
        end
    endtask

    // Returns once nothing is queued, on the wire, or awaiting its result.
    task wait_quiet();
        while (request_q.size() != 0 || req_if.valid || predicted_rsp_q.size() != 0)
            @(negedge i_clk);
    endtask

    // Request driver: predicts on each transfer, then offers the next queued item.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
        end else begin
            if (req_if.valid && req_if.ready) begin
                predicted_rsp_q = {predicted_rsp_q, predict_allocator_result(req_if.data)};
                req_done++;
            end
            if (!req_if.valid || req_if.ready) begin
                if (request_q.size() != 0 && !idle_now()) begin
                    req_if.data  <= request_q.pop_front();
                    req_if.valid <= 1'b1;
                end else begin
                    req_if.valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: checks each transfer against the oldest prediction and drives ready.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
        end else begin
            if (rsp_if.valid && rsp_if.ready) begin
                if (predicted_rsp_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("%0t: unexpected result slot %0d status %0d total %0d",
                                 $realtime, rsp_if.data.slot_out, rsp_if.data.status,
                                 rsp_if.data.total_refs);
                end else begin
                    rsp_want = predicted_rsp_q.pop_front();
                    if (rsp_if.data.slot_out !== rsp_want.slot_out ||
                        rsp_if.data.status !== rsp_want.status ||
                        rsp_if.data.total_refs !== rsp_want.total_refs) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS) begin
                            $write("%0t: result %0d expected slot %0d status %0d total %0d,",
                                   $realtime, rsp_done, rsp_want.slot_out, rsp_want.status,
                                   rsp_want.total_refs);
                            $display(" got slot %0d status %0d total %0d",
                                     rsp_if.data.slot_out, rsp_if.data.status,
                                     rsp_if.data.total_refs);
                        end
                    end
                end
                rsp_done++;
            end
            // One long hold-off on request, otherwise random back-pressure.
            if (hold_left > 0) begin
                hold_left--;
                rsp_if.ready <= 1'b0;
            end else if (hold_armed && !hold_taken) begin
                hold_taken = 1'b1;
                hold_left  = HOLD_CYCLES;
                rsp_if.ready <= 1'b0;
            end else begin
                rsp_if.ready <= !idle_now();
            end
        end
    end

    // Watchdog on cycles without any transfer.
    always @(posedge i_clk) begin
        if (!i_rst_n || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles == STALL_LIMIT) begin
            $display("refcounted_slot_allocator_top verification failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Stimulus: directed corner cases, then random batches separated by full drains.
    initial begin
        int   n_rand;
        int   batch;
        int   sz;
        int   r;
        t_mix mix;
        req_if.valid = 1'b0;
        req_if.data  = '0;
        rsp_if.ready = 1'b0;
        i_rst_n      = 1'b0;
        hold_armed   = 1'b0;
        hold_taken   = 1'b0;
        hold_left    = 0;
        full_seen    = 1'b0;
        req_done     = 0;
        rsp_done     = 0;
        mismatches   = 0;
        clear_allocator();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Dead slots, the unused kind, and the field extremes.
        push_req(rcsa_pkg::KIND_RELEASE, 10'd5, 16'hFFFF);
        push_req(rcsa_pkg::KIND_ADD, 10'd1023, 16'hFFFF);
        push_req(KIND_UNUSED, 10'd1023, 16'hFFFF);
        push_req(KIND_UNUSED, 10'd0, 16'h0000);
        // Fresh allocation, adding up to the ceiling, overflow, and a zero add.
        push_req(rcsa_pkg::KIND_ALLOC, 10'd1023, 16'hFFFF);
        push_req(rcsa_pkg::KIND_ADD, 10'd1, 16'hFFFE);
        push_req(rcsa_pkg::KIND_ADD, 10'd1, 16'h0001);
        push_req(rcsa_pkg::KIND_ADD, 10'd1, 16'h0000);
        push_req(rcsa_pkg::KIND_ADD, 10'd0, 16'hFFFF);
        // Free two slots, then try a double release and a revive.
        push_req(rcsa_pkg::KIND_ALLOC, 10'd0, 16'h0000);
        push_req(rcsa_pkg::KIND_ALLOC, 10'd0, 16'h0000);
        push_req(rcsa_pkg::KIND_RELEASE, 10'd2, 16'h0000);
        push_req(rcsa_pkg::KIND_RELEASE, 10'd3, 16'h0000);
        push_req(rcsa_pkg::KIND_RELEASE, 10'd2, 16'h0000);
        push_req(rcsa_pkg::KIND_ADD, 10'd3, 16'h0007);
        // Reuse comes back in last-freed-first order, then a fresh slot.
        push_req(rcsa_pkg::KIND_ALLOC, 10'd0, 16'h0000);
        push_req(rcsa_pkg::KIND_ALLOC, 10'd0, 16'h0000);
        push_req(rcsa_pkg::KIND_ALLOC, 10'd0, 16'h0000);
        push_req(rcsa_pkg::KIND_RELEASE, 10'd1, 16'h0000);
        // The reserved slot can be released and then handed out again.
        push_req(rcsa_pkg::KIND_RELEASE, 10'd4, 16'h0000);
        push_req(rcsa_pkg::KIND_RELEASE, 10'd0, 16'h0000);
        push_req(rcsa_pkg::KIND_ADD, 10'd4, 16'h0001);
        push_req(rcsa_pkg::KIND_ALLOC, 10'd0, 16'h0000);
        push_req(rcsa_pkg::KIND_ALLOC, 10'd0, 16'h0000);
        wait_quiet();

        // Mostly fill until the allocator has run out once, then drain and mix.
        n_rand = 0;
        batch  = 0;
        while ((n_rand < RANDOM_ITEMS || !full_seen) && n_rand < 2 * RANDOM_ITEMS) begin
            if (batch == 6) begin
                hold_armed = 1'b1;
                sz         = 160;
            end else begin
                sz = $urandom_range(20, 120);
            end
            r = $urandom_range(99);
            if (!full_seen)
                mix = (r < 90) ? MIX_FILL : MIX_DRAIN;
            else
                mix = (r < 45) ? MIX_DRAIN : (r < 80) ? MIX_BLEND : MIX_FILL;
            queue_random_batch(sz, mix);
            n_rand += sz;
            batch++;
            wait_quiet();
        end

        // Let any stray result surface before the verdict.
        repeat (20) @(posedge i_clk);
        if (mismatches == 0)
            $display("refcounted_slot_allocator_top verification clean");
        else
            $display("refcounted_slot_allocator_top verification failed");
        $finish;
    end

endmodule

@@ files.f @@
rtl/rcsa_pkg.sv
rtl/rcsa_ifs.sv
rtl/rcsa_count_mem.sv
rtl/rcsa_free_stack.sv
rtl/refcounted_slot_allocator_top.sv
bench/refcounted_slot_allocator_top_test.sv
